/* rtl/rcpw_pkg.sv */
// Package for the RC PWM pulse width capture block.
// Field widths, register indexes, status codes and the result struct.
// No dependencies.
package rcpw_pkg;

  localparam int unsigned ChannelsDefault = 6;
  localparam int unsigned ChanW           = 3;
  localparam int unsigned StampW          = 16;
  localparam int unsigned ShiftW          = 2;
  localparam int unsigned CfgIdxW         = 1;
  localparam int unsigned CfgDataW        = 16;

  localparam logic [StampW-1:0] RejectLimitReset = 16'd4000;
  localparam logic [ShiftW-1:0] TickShiftReset   = 2'd1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_REJECT_LIMIT = 1'b0,
    CFG_TICK_SHIFT   = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    STATUS_RISE   = 2'd0,
    STATUS_VALID  = 2'd1,
    STATUS_REJECT = 2'd2
  } status_e;

  typedef struct packed {
    status_e           status;
    logic [StampW-1:0] width;
  } result_t;

endpackage

/* rtl/rcpw_width_calc.sv */
// Pulse width arithmetic for one edge word: modular difference, limit check, shift.
// Depends on rcpw_pkg.
module rcpw_width_calc (
  input  logic                          awaiting_fall_i,
  input  logic [rcpw_pkg::StampW-1:0]   stamp_i,
  input  logic [rcpw_pkg::StampW-1:0]   rise_stamp_i,
  input  logic [rcpw_pkg::StampW-1:0]   reject_limit_i,
  input  logic [rcpw_pkg::ShiftW-1:0]   tick_shift_i,
  output rcpw_pkg::result_t             result_o
);

  logic [rcpw_pkg::StampW-1:0] diff;

  // 16-bit subtraction wraps naturally with the timer
  assign diff = stamp_i - rise_stamp_i;

  always_comb begin
    result_o.status = rcpw_pkg::STATUS_RISE;
    result_o.width  = '0;
    if (awaiting_fall_i) begin
      if (diff > reject_limit_i) begin
        result_o.status = rcpw_pkg::STATUS_REJECT;
      end else begin
        result_o.status = rcpw_pkg::STATUS_VALID;
        result_o.width  = diff >> tick_shift_i;
      end
    end
  end

endmodule

/* rtl/rc_pwm_pulse_width_capture.sv */
// Top level of the RC PWM pulse width capture block.
// Input register, per-channel state, result register. Uses rcpw_pkg, rcpw_width_calc.
//
//   channel  dir  handshake              payload
//   in       in   in_valid_i/in_ready_o  channel_i, stamp_i
//   out      out  out_valid_o/out_ready_i out_channel_o, status_o, width_o
//   cfg      in   cfg_we_i (no wait)     cfg_index_i, cfg_data_i
//
// One word per cycle unless the output stalls; words pass the input register,
// then the result register. The channel state is read and written in the same
// stage, so back-to-back words on one channel see each other's updates.
// Reset disarms every channel and loads the register defaults.
// A stalled output holds the result; the input register still takes one word.
// Channel numbers at or above CHANNELS are dropped with no result.
module rc_pwm_pulse_width_capture #(
  parameter int unsigned CHANNELS = rcpw_pkg::ChannelsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rcpw_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rcpw_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [rcpw_pkg::ChanW-1:0]    channel_i,
  input  logic [rcpw_pkg::StampW-1:0]   stamp_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [rcpw_pkg::ChanW-1:0]    out_channel_o,
  output logic [1:0]                    status_o,
  output logic [rcpw_pkg::StampW-1:0]   width_o
);

  localparam int unsigned IdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Configuration registers
  logic [rcpw_pkg::StampW-1:0] reject_limit_q;
  logic [rcpw_pkg::ShiftW-1:0] tick_shift_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reject_limit_q <= rcpw_pkg::RejectLimitReset;
      tick_shift_q   <= rcpw_pkg::TickShiftReset;
    end else if (cfg_we_i) begin
      unique case (rcpw_pkg::cfg_idx_e'(cfg_index_i))
        rcpw_pkg::CFG_REJECT_LIMIT: reject_limit_q <= cfg_data_i;
        rcpw_pkg::CFG_TICK_SHIFT:   tick_shift_q   <= cfg_data_i[rcpw_pkg::ShiftW-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  logic                        in_valid_q;
  logic [rcpw_pkg::ChanW-1:0]  ch_q;
  logic [rcpw_pkg::StampW-1:0] stamp_q;
  logic                        advance;
  logic                        fire;

  assign advance    = !out_valid_o || out_ready_i;
  assign in_ready_o = !in_valid_q || advance;
  assign fire       = in_valid_q && advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      ch_q    <= channel_i;
      stamp_q <= stamp_i;
    end
  end

  // Channel decode; the index is widened first so CHANNELS above 8 still fits
  logic [31:0]     ch_ext;
  logic [IdxW-1:0] idx;
  logic            in_range;

  assign ch_ext   = 32'(ch_q);
  assign idx      = ch_ext[IdxW-1:0];
  assign in_range = ch_ext < CHANNELS;

  // Per-channel state: armed flag (reset) and rising stamp (read only when armed)
  logic [CHANNELS-1:0]         awaiting_fall_q;
  logic [rcpw_pkg::StampW-1:0] rise_stamp_q [CHANNELS];
  logic                        armed;
  logic [rcpw_pkg::StampW-1:0] rise_rd;

  assign armed   = in_range ? awaiting_fall_q[idx] : 1'b0;
  assign rise_rd = in_range ? rise_stamp_q[idx] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      awaiting_fall_q <= '0;
    end else if (fire && in_range) begin
      awaiting_fall_q[idx] <= !armed;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && in_range && !armed) begin
      rise_stamp_q[idx] <= stamp_q;
    end
  end

  rcpw_pkg::result_t result;

  rcpw_width_calc u_width_calc (
    .awaiting_fall_i (armed),
    .stamp_i         (stamp_q),
    .rise_stamp_i    (rise_rd),
    .reject_limit_i  (reject_limit_q),
    .tick_shift_i    (tick_shift_q),
    .result_o        (result)
  );

  // Result register
  logic                        out_valid_q;
  logic [rcpw_pkg::ChanW-1:0]  out_ch_q;
  rcpw_pkg::result_t           result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= fire && in_range;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && in_range) begin
      out_ch_q <= ch_q;
      result_q <= result;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_channel_o = out_ch_q;
  assign status_o      = result_q.status;
  assign width_o       = result_q.width;

endmodule
